// File: rtl/tmhq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer min-heap queue package
// Operation and result codes, fixed field widths and the controller states.
// ---------------------------------------------------------------------------
package tmhq_pkg;

	localparam int CONN_W    = 10;
	localparam int TIMEOUT_W = 31;
	localparam int NOW_W     = 47;
	localparam int WAIT_W    = 32;

	localparam logic [WAIT_W-1:0] WAIT_MAX   = 32'h7FFF_FFFF;
	localparam logic [WAIT_W-1:0] WAIT_EMPTY = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_UPDATE = 2'd1,
		FN_CANCEL = 2'd2,
		FN_TICK   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_CLOSED = 2'd1,
		KIND_WAIT   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DEC,
		ST_CAN_WR,
		ST_SU_START,
		ST_SU_CMP,
		ST_SD_START,
		ST_SD_LEFT,
		ST_SD_CMP,
		ST_PLACE,
		ST_ACK,
		ST_TK_RD,
		ST_TK_CHK,
		ST_POP_RD
	} state_t;

endpackage

// File: rtl/timer_min_heap_queue_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer min-heap queue
// Connection timers held in a binary min-heap ordered by expiry time.
// ---------------------------------------------------------------------------
// The block keeps one timer per connection in a binary min-heap stored in a
// synchronous RAM, with a second RAM mapping each connection to its heap
// slot and a valid bit. After reset a clearing pass writes every entry of
// the connection map, during which no transaction is accepted. Items are
// handled one at a time. An add moves its entry upwards level by level, an
// update upwards and then downwards, and a cancel only marks its entry
// cancelled; each level costs a registered RAM read followed by a compare
// and a write-back. A tick reads the root and, for each popped entry that
// leaves the heap non-empty, reads the last entry and sifts it down from
// the root. Every item yields one final result transaction; a tick also
// yields one per closed connection ahead of its final one, which carries
// the wait until the next expiry.
// ---------------------------------------------------------------------------
module timer_min_heap_queue_top
	import tmhq_pkg::*;
#(
	parameter int CAPACITY  = 32,
	parameter int CONN_IDS  = 1024,
	parameter int TIME_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input transaction.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // conn_id[9:0], timeout_ms[40:10], now_ms[87:41]
	input  logic [1:0]  s_tuser,  // func[1:0]
	// Result transaction.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // closed_conn[9:0], wait_ms[41:10], ok[42], zero pad
	output logic [1:0]  m_tuser,  // kind[1:0]
	output logic        m_tlast   // last
);

	localparam int SW    = $clog2(CAPACITY);
	localparam int CNTW  = $clog2(CAPACITY + 1);
	localparam int IW    = SW + 2;
	localparam int ID_W  = $clog2(CONN_IDS);
	localparam int ENT_W = TIME_BITS + CONN_W + 1;
	localparam int MAP_W = SW + 1;
	localparam int CMP_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

	state_t state_q, state_d;

	// Heap RAM: {cancelled, owner, expiry}.
	logic             h_we, h_re;
	logic [SW-1:0]    h_waddr, h_raddr;
	logic [ENT_W-1:0] h_wdata, h_rdata;
	// Connection map RAM: {valid, slot}.
	logic             m_we, m_re;
	logic [ID_W-1:0]  m_waddr, m_raddr;
	logic [MAP_W-1:0] m_wdata, m_rdata;

	tmhq_ram #(.DATA_W(ENT_W), .DEPTH(CAPACITY)) u_heap_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata)
	);

	tmhq_ram #(.DATA_W(MAP_W), .DEPTH(CONN_IDS)) u_map_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(m_re), .raddr(m_raddr), .rdata(m_rdata)
	);

	// Item registers.
	func_t                op_q;
	logic [CONN_W-1:0]    conn_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [NOW_W-1:0]     now_q;
	// Heap walk registers.
	logic [CNTW-1:0]      cnt_q;
	logic [SW-1:0]        i_q, p_q;
	logic [ENT_W-1:0]     cur_q, left_q;
	logic                 has_r_q;
	logic [ID_W-1:0]      clr_q;
	// Pending final result.
	kind_t                pend_kind_q;
	logic [WAIT_W-1:0]    pend_wait_q;
	logic                 pend_ok_q;
	// Output register.
	logic                 out_valid_q, out_last_q, out_ok_q;
	kind_t                out_kind_q;
	logic [CONN_W-1:0]    out_conn_q;
	logic [WAIT_W-1:0]    out_wait_q;

	logic                 accept, can_emit;
	logic [TIME_BITS-1:0] h_exp, l_exp, cur_exp, best_exp;
	logic [CONN_W-1:0]    h_own, cur_own;
	logic                 h_can;
	logic [CMP_W:0]       diff;
	logic                 pop, sat;
	logic [WAIT_W-1:0]    wait_val;
	logic                 id_valid, has;
	logic [SW-1:0]        slot, parent, child_idx;
	logic [IW-1:0]        l_w, r_w, cnt_w;
	logic                 l_in, r_in, left_lt, right_lt, moved;
	logic [ENT_W-1:0]     child;
	logic [CNTW-1:0]      cnt_dec;
	logic [NOW_W+1-1:0]   sum;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign can_emit = !out_valid_q || m_tready;

	assign sum = {1'b0, s_tdata[87:41]} + (NOW_W + 1)'(s_tdata[40:10]);

	assign h_exp   = h_rdata[TIME_BITS-1:0];
	assign h_own   = h_rdata[TIME_BITS+CONN_W-1:TIME_BITS];
	assign h_can   = h_rdata[ENT_W-1];
	assign l_exp   = left_q[TIME_BITS-1:0];
	assign cur_exp = cur_q[TIME_BITS-1:0];
	assign cur_own = cur_q[TIME_BITS+CONN_W-1:TIME_BITS];

	// Root check: the borrow of expiry minus now marks an expired entry.
	assign diff     = {1'b0, CMP_W'(h_exp)} - {1'b0, CMP_W'(now_q)};
	assign pop      = h_can || diff[CMP_W];
	assign sat      = |diff[CMP_W-1:WAIT_W-1];
	assign wait_val = sat ? WAIT_MAX : {1'b0, diff[WAIT_W-2:0]};

	assign id_valid = (32'(conn_q) < CONN_IDS);
	assign has      = id_valid && m_rdata[SW];
	assign slot     = m_rdata[SW-1:0];
	assign parent   = (i_q - SW'(1)) >> 1;
	assign cnt_dec  = cnt_q - CNTW'(1);

	assign l_w   = {1'b0, i_q, 1'b1};
	assign r_w   = l_w + IW'(1);
	assign cnt_w = IW'(cnt_q);
	assign l_in  = l_w < cnt_w;
	assign r_in  = r_w < cnt_w;

	// Sift-down choice between the hole's entry and its one or two children.
	assign left_lt   = l_exp < cur_exp;
	assign best_exp  = left_lt ? l_exp : cur_exp;
	assign right_lt  = has_r_q && (h_exp < best_exp);
	assign moved     = left_lt || right_lt;
	assign child     = right_lt ? h_rdata : left_q;
	assign child_idx = right_lt ? SW'(r_w) : SW'(l_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM port control.
	always_comb begin
		state_d = state_q;
		h_we    = 1'b0;
		h_waddr = i_q;
		h_wdata = cur_q;
		h_re    = 1'b0;
		h_raddr = i_q;
		m_we    = 1'b0;
		m_waddr = ID_W'(cur_own);
		m_wdata = {1'b1, i_q};
		m_re    = 1'b0;
		m_raddr = ID_W'(s_tdata[9:0]);
		unique case (state_q)
			ST_CLR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
				m_wdata = '0;
				if (clr_q == ID_W'(CONN_IDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					m_re    = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				unique case (op_q)
					FN_ADD: begin
						if (!id_valid || has || cnt_q == CNTW'(CAPACITY)) begin
							state_d = ST_ACK;
						end else begin
							state_d = ST_SU_START;
						end
					end
					FN_UPDATE: state_d = has ? ST_SU_START : ST_ACK;
					FN_CANCEL: begin
						if (has) begin
							h_re    = 1'b1;
							h_raddr = slot;
							state_d = ST_CAN_WR;
						end else begin
							state_d = ST_ACK;
						end
					end
					default: state_d = ST_TK_RD;
				endcase
			end
			ST_CAN_WR: begin
				h_we    = 1'b1;
				h_waddr = i_q;
				h_wdata = {1'b1, h_rdata[ENT_W-2:0]};
				state_d = ST_ACK;
			end
			ST_SU_START: begin
				if (i_q == '0) begin
					state_d = (op_q == FN_UPDATE) ? ST_SD_START : ST_PLACE;
				end else begin
					h_re    = 1'b1;
					h_raddr = parent;
					state_d = ST_SU_CMP;
				end
			end
			ST_SU_CMP: begin
				if (h_exp > cur_exp) begin
					h_we    = 1'b1;
					h_wdata = h_rdata;
					m_we    = 1'b1;
					m_waddr = ID_W'(h_own);
					state_d = ST_SU_START;
				end else begin
					state_d = (op_q == FN_UPDATE) ? ST_SD_START : ST_PLACE;
				end
			end
			ST_SD_START: begin
				if (l_in) begin
					h_re    = 1'b1;
					h_raddr = SW'(l_w);
					state_d = ST_SD_LEFT;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_SD_LEFT: begin
				if (r_in) begin
					h_re    = 1'b1;
					h_raddr = SW'(r_w);
				end
				state_d = ST_SD_CMP;
			end
			ST_SD_CMP: begin
				if (moved) begin
					h_we    = 1'b1;
					h_wdata = child;
					m_we    = 1'b1;
					m_waddr = ID_W'(child[TIME_BITS+CONN_W-1:TIME_BITS]);
					state_d = ST_SD_START;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				h_we    = 1'b1;
				m_we    = 1'b1;
				state_d = (op_q == FN_TICK) ? ST_TK_RD : ST_ACK;
			end
			ST_ACK: begin
				if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_TK_RD: begin
				if (cnt_q == '0) begin
					state_d = ST_ACK;
				end else begin
					h_re    = 1'b1;
					h_raddr = '0;
					state_d = ST_TK_CHK;
				end
			end
			ST_TK_CHK: begin
				if (!pop) begin
					state_d = ST_ACK;
				end else if (can_emit) begin
					m_we    = 1'b1;
					m_waddr = ID_W'(h_own);
					m_wdata = '0;
					if (cnt_dec != '0) begin
						h_re    = 1'b1;
						h_raddr = SW'(cnt_dec);
						state_d = ST_POP_RD;
					end else begin
						state_d = ST_TK_RD;
					end
				end
			end
			ST_POP_RD: state_d = ST_SD_START;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + ID_W'(1);
			end
			if (state_q == ST_DEC && op_q == FN_ADD && state_d == ST_SU_START) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			if (state_q == ST_TK_CHK && pop && can_emit) begin
				cnt_q <= cnt_dec;
			end
			if ((state_q == ST_ACK && can_emit) || (state_q == ST_TK_CHK && pop && can_emit)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= func_t'(s_tuser);
			conn_q <= s_tdata[9:0];
			now_q  <= s_tdata[87:41];
			exp_q  <= TIME_BITS'(sum);
		end
		case (state_q)
			ST_DEC: begin
				pend_kind_q <= KIND_ACK;
				pend_wait_q <= '0;
				pend_ok_q   <= 1'b0;
				if (op_q == FN_ADD) begin
					i_q       <= SW'(cnt_q);
					pend_ok_q <= (state_d == ST_SU_START);
				end else begin
					i_q       <= slot;
					pend_ok_q <= has;
				end
				cur_q <= {1'b0, conn_q, exp_q};
			end
			ST_SU_START: p_q <= parent;
			ST_SU_CMP: begin
				if (h_exp > cur_exp) begin
					i_q <= p_q;
				end
			end
			ST_SD_LEFT: begin
				left_q  <= h_rdata;
				has_r_q <= r_in;
			end
			ST_SD_CMP: begin
				if (moved) begin
					i_q <= child_idx;
				end
			end
			ST_TK_RD: begin
				pend_kind_q <= KIND_WAIT;
				pend_wait_q <= WAIT_EMPTY;
				pend_ok_q   <= 1'b1;
			end
			ST_TK_CHK: begin
				pend_wait_q <= wait_val;
			end
			ST_POP_RD: begin
				cur_q <= h_rdata;
				i_q   <= '0;
			end
			default: ;
		endcase
		if (state_q == ST_ACK && can_emit) begin
			out_kind_q <= pend_kind_q;
			out_conn_q <= '0;
			out_wait_q <= pend_wait_q;
			out_ok_q   <= pend_ok_q;
			out_last_q <= 1'b1;
		end else if (state_q == ST_TK_CHK && pop && can_emit) begin
			out_kind_q <= KIND_CLOSED;
			out_conn_q <= h_own;
			out_wait_q <= '0;
			out_ok_q   <= 1'b1;
			out_last_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_ok_q, out_wait_q, out_conn_q};

	// The heap never holds more than its capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(CAPACITY))
		else $error("heap count beyond capacity");

	// Only one item is in progress: an accepted item closes the input.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// A refusal is only ever an acknowledge.
	a_refuse_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[42]) |-> (m_tuser == KIND_ACK))
		else $error("refusal on a tick result");

	// A closed connection is never the final result of an item.
	a_closed_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_CLOSED) |-> !m_tlast)
		else $error("closed connection marked last");

endmodule

// File: rtl/tmhq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer queue RAM
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data until the next read.
// ---------------------------------------------------------------------------
module tmhq_ram
	import tmhq_pkg::*;
#(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
